### rtl/lsfr_pkg.sv
// Shared types, constants and helper functions for the LIN slave frame responder.
package lsfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [5:0] SHORT_ID_MAX = 6'd31;
  localparam logic [5:0] MID_ID_MAX = 6'd47;
  localparam logic [5:0] FRAME_ID_RESET = 6'd50;

  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_SYNC_ERR = 2'd1;
  localparam logic [1:0] KIND_PID_ERR = 2'd2;

  localparam logic CFG_FRAME_ID = 1'b0;
  localparam logic CFG_RESPONSE_DATA = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_PID  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TX_IDLE = 2'd0,
    TX_DATA = 2'd1,
    TX_CSUM = 2'd2
  } tx_state_t;

  typedef enum logic [1:0] {
    CMD_SYNC_ERR = 2'd0,
    CMD_PID_ERR  = 2'd1,
    CMD_RESPOND  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] pid;
    logic [2:0] last_idx;
  } cmd_t;

  function automatic logic [7:0] protected_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Index of the final data byte: 2, 4 or 8 bytes by id range.
  function automatic logic [2:0] last_index(input logic [5:0] id);
    logic [2:0] li;
    if (id <= SHORT_ID_MAX) begin
      li = 3'd1;
    end else if (id <= MID_ID_MAX) begin
      li = 3'd3;
    end else begin
      li = 3'd7;
    end
    return li;
  endfunction

endpackage

### rtl/lsfr_if.sv
// Valid/ready channel interfaces for received bytes and response results.
interface lsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       framing_error;
  modport source(output valid, output rx_byte, output framing_error, input ready);
  modport sink(input valid, input rx_byte, input framing_error, output ready);
endinterface

interface lsfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       last;
  modport source(output valid, output kind, output tx_byte, output last, input ready);
  modport sink(input valid, input kind, input tx_byte, input last, output ready);
endinterface

### rtl/lsfr_header_parser.sv
// Front end: tracks break, sync and PID bytes and queues a command per header outcome.
module lsfr_header_parser (
  input  logic          clk,
  input  logic          rst,
  lsfr_in_if.sink       rx_in,
  input  logic [5:0]    frame_id,
  input  logic          full,
  output logic          push,
  output lsfr_pkg::cmd_t cmd
);
  import lsfr_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   accept;

  assign rx_in.ready = ~full;
  assign accept = rx_in.valid & rx_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_SYNC: begin
          if (rx_in.rx_byte == SYNC_BYTE) begin
            phase_next = PH_PID;
          end else if (rx_in.rx_byte != 8'd0) begin
            phase_next = PH_IDLE;
          end
        end
        PH_PID: phase_next = PH_IDLE;
        default: begin
          if (rx_in.rx_byte == 8'd0 && rx_in.framing_error) begin
            phase_next = PH_SYNC;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    push = 1'b0;
    cmd.op = CMD_SYNC_ERR;
    cmd.pid = protected_id(frame_id);
    cmd.last_idx = last_index(frame_id);
    if (accept) begin
      unique case (phase)
        PH_SYNC: begin
          if (rx_in.rx_byte != 8'd0 && rx_in.rx_byte != SYNC_BYTE) begin
            push = 1'b1;
          end
        end
        PH_PID: begin
          push = 1'b1;
          cmd.op = (rx_in.rx_byte == cmd.pid) ? CMD_RESPOND : CMD_PID_ERR;
        end
        default: push = 1'b0;
      endcase
    end
  end

`ifndef SYNTH
  a_pid_beat_queues: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_PID) |-> push)
    else $error("PID beat did not queue a command");
`endif

endmodule

### rtl/lsfr_cmd_fifo.sv
// Two-entry command queue between the header parser and the transmit sequencer.
module lsfr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsfr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lsfr_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import lsfr_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
`endif
`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue underflow");
`endif

endmodule

### rtl/lsfr_response_tx.sv
// Back end: turns queued commands into result beats, one byte per beat, with checksum.
module lsfr_response_tx (
  input  logic           clk,
  input  logic           rst,
  input  lsfr_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  input  logic [63:0]    response_data,
  lsfr_out_if.source     tx_out
);
  import lsfr_pkg::*;

  tx_state_t  state;
  tx_state_t  state_next;
  logic [2:0] idx;
  logic [2:0] last_idx;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic [8:0] sum_wide;
  logic [7:0] data_byte;
  logic       adv;
  logic       load;
  logic [1:0] kind_d;
  logic [7:0] byte_d;
  logic       last_d;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  assign tx_out.valid = out_valid;
  assign tx_out.kind = out_kind;
  assign tx_out.tx_byte = out_byte;
  assign tx_out.last = out_last;

  assign adv = ~out_valid | tx_out.ready;
  assign data_byte = response_data[{idx, 3'b000} +: 8];
  // End-around carry: a carry out of bit 7 wraps back into bit 0.
  assign sum_wide = {1'b0, sum} + {1'b0, data_byte};
  assign sum_next = sum_wide[7:0] + {7'd0, sum_wide[8]};

  always_comb begin
    state_next = state;
    unique case (state)
      TX_IDLE: begin
        if (adv && !empty && head.op == CMD_RESPOND) begin
          state_next = TX_DATA;
        end
      end
      TX_DATA: begin
        if (adv && idx == last_idx) begin
          state_next = TX_CSUM;
        end
      end
      TX_CSUM: begin
        if (adv) begin
          state_next = TX_IDLE;
        end
      end
      default: state_next = TX_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load = 1'b0;
    kind_d = KIND_TX;
    byte_d = 8'd0;
    last_d = 1'b0;
    unique case (state)
      TX_IDLE: begin
        pop = adv & ~empty;
        if (pop && head.op != CMD_RESPOND) begin
          load = 1'b1;
          kind_d = (head.op == CMD_SYNC_ERR) ? KIND_SYNC_ERR : KIND_PID_ERR;
          last_d = 1'b1;
        end
      end
      TX_DATA: begin
        load = adv;
        byte_d = data_byte;
      end
      TX_CSUM: begin
        load = adv;
        byte_d = ~sum;
        last_d = 1'b1;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TX_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (tx_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= kind_d;
      out_byte <= byte_d;
      out_last <= last_d;
    end
    if (pop) begin
      idx <= 3'd0;
      sum <= head.pid;
      last_idx <= head.last_idx;
    end else if (state == TX_DATA && adv) begin
      idx <= idx + 3'd1;
      sum <= sum_next;
    end
  end

`ifndef SYNTH
  a_csum_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == TX_CSUM && adv) |=> (tx_out.valid && tx_out.last && tx_out.kind == KIND_TX))
    else $error("checksum beat not marked last");
`endif

endmodule

### rtl/lin_slave_frame_responder.sv
// LIN slave frame responder: header parser, command queue and response sequencer.
// A sync or PID error beat is registered in the command queue, then in the output register.
// A matched PID is answered by the byte-serial transmit sequencer: two, four or eight data
// bytes by frame id range, then the checksum byte.
// Input bytes are taken every cycle while the two-entry command queue has room.
// Reset: phase idle, frame_id 50, response_data 0, queue and output register empty.
module lin_slave_frame_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  lsfr_in_if.sink     rx_in,
  lsfr_out_if.source  tx_out
);
  import lsfr_pkg::*;

  logic [5:0]  frame_id;
  logic [63:0] response_data;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  cmd_t        push_cmd;
  cmd_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id <= FRAME_ID_RESET;
      response_data <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_ID:      frame_id <= cfg_data[5:0];
        CFG_RESPONSE_DATA: response_data <= cfg_data;
        default:           frame_id <= frame_id;
      endcase
    end
  end

  lsfr_header_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx_in    (rx_in),
    .frame_id (frame_id),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  lsfr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  lsfr_response_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .response_data (response_data),
    .tx_out        (tx_out)
  );

endmodule

### dv/tb.sv
// Self-checking testbench for the LIN slave frame responder.
`timescale 1ns / 100ps

module tb;
  import lsfr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       framing_error;
  } rx_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
  } resp_beat_t;

  typedef enum {FR_MATCH, FR_PID_MISS, FR_SYNC_MISS} frame_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  lsfr_in_if  rx_in ();
  lsfr_out_if tx_out ();

  lin_slave_frame_responder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx_in    (rx_in),
    .tx_out   (tx_out)
  );

  // Shadow copy of the responder state, advanced on every accepted byte.
  phase_t      hdr_phase;
  logic [5:0]  model_frame_id;
  logic [63:0] model_resp_data;

  rx_beat_t    byte_backlog[$];
  resp_beat_t  pending_results[$];
  int unsigned bytes_outstanding;
  int unsigned fail_count;

  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          tx_gap_off;
  bit          rx_stall_off;
  bit          long_hold_req;
  rx_beat_t    next_beat;
  resp_beat_t  want;

  logic [5:0]  id_plan[PHASE_COUNT];
  logic [63:0] data_plan[PHASE_COUNT];

  always #5 clk = ~clk;

  function automatic logic [7:0] lin_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Mostly back to back, some short gaps and an occasional long one.
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic expect_beat(input logic [1:0] kind, input logic [7:0] b, input logic last);
    pending_results.push_back({kind, b, last});
  endtask

  task automatic predict_response(input logic [7:0] rx, input logic fe);
    logic [7:0] pid;
    logic [8:0] sum;
    logic [7:0] b;
    int unsigned len;
    case (hdr_phase)
      PH_SYNC: begin
        if (rx == SYNC_BYTE) begin
          hdr_phase = PH_PID;
        end else if (rx != 8'h00) begin
          hdr_phase = PH_IDLE;
          expect_beat(KIND_SYNC_ERR, 8'h00, 1'b1);
        end
      end
      PH_PID: begin
        hdr_phase = PH_IDLE;
        pid = lin_pid(model_frame_id);
        if (rx != pid) begin
          expect_beat(KIND_PID_ERR, 8'h00, 1'b1);
        end else begin
          len = (model_frame_id <= SHORT_ID_MAX) ? 2 : (model_frame_id <= MID_ID_MAX) ? 4 : 8;
          sum = {1'b0, pid};
          for (int i = 0; i < len; i++) begin
            b = model_resp_data[8*i +: 8];
            sum = sum + b;
            // End-around carry keeps the running sum within a byte.
            if (sum > 9'd255) begin
              sum = sum - 9'd255;
            end
            expect_beat(KIND_TX, b, 1'b0);
          end
          expect_beat(KIND_TX, ~sum[7:0], 1'b1);
        end
      end
      default: begin
        hdr_phase = (rx == 8'h00 && fe) ? PH_SYNC : PH_IDLE;
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fe);
    byte_backlog.push_back({b, fe});
    bytes_outstanding++;
  endtask

  task automatic queue_frame(input frame_mode_t mode, input int unsigned zeros);
    logic [7:0] good_pid;
    logic [7:0] b;
    good_pid = lin_pid(model_frame_id);
    queue_byte(8'h00, 1'b1);
    repeat (zeros) queue_byte(8'h00, 1'($urandom_range(0, 1)));
    if (mode == FR_SYNC_MISS) begin
      do b = 8'($urandom); while (b == 8'h00 || b == SYNC_BYTE);
      queue_byte(b, 1'($urandom_range(0, 1)));
    end else begin
      queue_byte(SYNC_BYTE, 1'($urandom_range(0, 1)));
      if (mode == FR_MATCH) begin
        b = good_pid;
      end else begin
        do b = 8'($urandom); while (b == good_pid);
      end
      queue_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_random_traffic(input int unsigned target);
    int unsigned counted;
    int unsigned r;
    int unsigned zeros;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      zeros = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
      if (r < 62) begin
        queue_frame(FR_MATCH, zeros);
        counted += 3 + zeros;
      end else if (r < 74) begin
        queue_frame(FR_PID_MISS, zeros);
        counted += 3 + zeros;
      end else if (r < 84) begin
        queue_frame(FR_SYNC_MISS, zeros);
        counted += 2 + zeros;
      end else begin
        queue_byte(8'($urandom), 1'($urandom_range(0, 1)));
        counted += 1;
      end
    end
  endtask

  task automatic wait_for_drain();
    do @(posedge clk); while (bytes_outstanding != 0 || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_FRAME_ID) begin
      model_frame_id = value[5:0];
    end else begin
      model_resp_data = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender side: one byte beat at a time from the backlog.
  always @(posedge clk) begin
    if (rst) begin
      rx_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (rx_in.valid && rx_in.ready) begin
        predict_response(rx_in.rx_byte, rx_in.framing_error);
        bytes_outstanding--;
      end
      if (!rx_in.valid || rx_in.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          rx_in.valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          next_beat = byte_backlog.pop_front();
          rx_in.valid <= 1'b1;
          rx_in.rx_byte <= next_beat.rx_byte;
          rx_in.framing_error <= next_beat.framing_error;
          send_gap = tx_gap_off ? 0 : rand_gap();
        end else begin
          rx_in.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      tx_out.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (tx_out.valid && tx_out.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat: kind %0d byte %02h last %0d", $time,
                   tx_out.kind, tx_out.tx_byte, tx_out.last);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (tx_out.kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, tx_out.kind);
            fail_count++;
          end
          if (tx_out.tx_byte !== want.tx_byte) begin
            $display("%0t: tx_byte mismatch: expected %02h, got %02h", $time, want.tx_byte,
                     tx_out.tx_byte);
            fail_count++;
          end
          if (tx_out.last !== want.last) begin
            $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, tx_out.last);
            fail_count++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        tx_out.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        tx_out.ready <= 1'b0;
      end else begin
        tx_out.ready <= 1'b1;
        recv_stall = rx_stall_off ? 0 : rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_in.valid && rx_in.ready) || (tx_out.valid && tx_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** lin_slave_frame_responder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_ID;
    cfg_data = '0;
    rx_in.valid = 1'b0;
    rx_in.rx_byte = 8'h00;
    rx_in.framing_error = 1'b0;
    tx_out.ready = 1'b0;
    hdr_phase = PH_IDLE;
    model_frame_id = FRAME_ID_RESET;
    model_resp_data = '0;
    bytes_outstanding = 0;
    fail_count = 0;
    tx_gap_off = 1'b0;
    rx_stall_off = 1'b0;
    long_hold_req = 1'b0;
    quiet_cycles = 0;

    id_plan = '{6'd0, 6'd31, 6'd32, 6'd47, 6'd48, 6'd63, 6'($urandom), 6'($urandom)};
    data_plan = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {$urandom, $urandom},
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, {$urandom, $urandom},
                  {$urandom, $urandom}, 64'h0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run on the reset register values.
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_frame(FR_MATCH, 0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(SYNC_BYTE, 1'b1);
    queue_byte(lin_pid(model_frame_id), 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h54, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(SYNC_BYTE, 1'b0);
    queue_byte(lin_pid(model_frame_id) ^ 8'h80, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(SYNC_BYTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(SYNC_BYTE, 1'b0);
    queue_byte(8'hFF, 1'b1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_for_drain();
      write_register(CFG_FRAME_ID, {58'd0, id_plan[p]});
      write_register(CFG_RESPONSE_DATA, data_plan[p]);
      tx_gap_off = (p == 5) || (p == 6);
      rx_stall_off = (p == 5) || (p == 7);
      if (p == 3) begin
        // Hold the receiver off while headers keep arriving so the block backs up.
        tx_gap_off = 1'b1;
        long_hold_req = 1'b1;
        repeat (6) queue_frame(FR_MATCH, 0);
      end
      queue_random_traffic(ITEMS_PER_PHASE);
      // Leave the header parser idle before the next register write.
      queue_byte(8'hFF, 1'b0);
    end

    wait_for_drain();
    if (fail_count == 0) begin
      $display("** lin_slave_frame_responder: PASSED **");
    end else begin
      $display("** lin_slave_frame_responder: FAILED **");
    end
    $finish;
  end

endmodule
